[design/token_field_splitter_defines.svh]
// Assertion helpers used by tfs_back.
`ifndef TOKEN_FIELD_SPLITTER_DEFINES_SVH
`define TOKEN_FIELD_SPLITTER_DEFINES_SVH

// Plain property, sampled on clk, off during reset.
`define TFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define TFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/tfs_pkg.sv]
package tfs_pkg;

  localparam int MAX_SESSION = 1024;
  localparam int MAC_CHARS   = 64;
  localparam int I64_CHARS   = 20;
  localparam int TOKEN_LIMIT = MAX_SESSION + 1 + I64_CHARS + 1 + MAC_CHARS + 4;
  localparam int CNT_W       = $clog2(TOKEN_LIMIT + 2);
  localparam int SESS_W      = 11;
  localparam int WIDE_W      = CNT_W + SESS_W;
  localparam int EXP_CNT_W   = 5;
  localparam int EXP_W       = 64;
  localparam int PROD_W      = EXP_W + 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WIDE_W-1:0]    wide_t;
  typedef logic [SESS_W-1:0]    sess_t;
  typedef logic [EXP_CNT_W-1:0] exp_cnt_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [Q_CNT_W-1:0]   q_cnt_t;

  localparam cnt_t     TOKEN_LIMIT_C = cnt_t'(TOKEN_LIMIT);
  localparam cnt_t     MAC_CHARS_C   = cnt_t'(MAC_CHARS);
  localparam wide_t    SESS_MAX_C    = wide_t'((1 << SESS_W) - 1);
  localparam sess_t    CAP_RESET_C   = sess_t'(1024);
  localparam exp_cnt_t EXP_CNT_MAX_C = '1;
  localparam q_cnt_t   Q_DEPTH_C     = q_cnt_t'(Q_DEPTH);
  localparam prod_t    POS_BOUND_C   = prod_t'(64'h7fff_ffff_ffff_ffff);
  localparam prod_t    NEG_BOUND_C   = prod_t'(64'h8000_0000_0000_0000);

  localparam logic [7:0] SEP_BYTE   = 8'h1e;
  localparam logic [7:0] MINUS_BYTE = 8'h2d;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  // Field tags
  localparam logic [1:0] FIELD_SESSION = 2'd0;
  localparam logic [1:0] FIELD_EXPIRY  = 2'd1;
  localparam logic [1:0] FIELD_MAC     = 2'd2;
  localparam logic [1:0] FIELD_OTHER   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LONG   = 3'd1;
  localparam logic [2:0] ST_FIELD_CNT  = 3'd2;
  localparam logic [2:0] ST_MAC_LEN    = 3'd3;
  localparam logic [2:0] ST_BAD_EXPIRY = 3'd4;
  localparam logic [2:0] ST_OVER_CAP   = 3'd5;

  localparam logic [1:0] SEP_TWO = 2'd2;

  typedef struct packed {
    logic too_long;
    logic sep_bad;
    logic mac_bad;
    logic over_cap;
  } tfs_flags_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] tag;
    logic       last;
    tfs_flags_t flags;
    sess_t      sess_len;
  } tfs_entry_t;

endpackage

[design/tfs_front.sv]
module tfs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  tfs_pkg::sess_t      cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_ready,
  output logic                q_push,
  output tfs_pkg::tfs_entry_t q_entry
);

  tfs_pkg::sess_t cap_r;
  logic [1:0]     sep_cnt_r, sep_cnt_nxt;
  tfs_pkg::cnt_t  byte_cnt_r, byte_cnt_nxt;
  tfs_pkg::cnt_t  sess_len_r, sess_len_nxt;
  tfs_pkg::cnt_t  mac_len_r, mac_len_nxt;
  tfs_pkg::wide_t sess_wide;
  logic           is_sep;
  logic           accept;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign q_push    = accept;
  assign is_sep    = (in_tdata == tfs_pkg::SEP_BYTE);

  always_comb begin
    sep_cnt_nxt  = sep_cnt_r;
    sess_len_nxt = sess_len_r;
    mac_len_nxt  = mac_len_r;
    byte_cnt_nxt = byte_cnt_r;
    if (byte_cnt_r <= tfs_pkg::TOKEN_LIMIT_C) begin
      byte_cnt_nxt = byte_cnt_r + tfs_pkg::cnt_t'(1);
    end
    q_entry.tag = tfs_pkg::FIELD_OTHER;
    if (is_sep) begin
      if (sep_cnt_r != 2'd3) begin
        sep_cnt_nxt = sep_cnt_r + 2'd1;
      end
    end else begin
      case (sep_cnt_r)
        2'd0: begin
          q_entry.tag = tfs_pkg::FIELD_SESSION;
          if (sess_len_r <= tfs_pkg::TOKEN_LIMIT_C) begin
            sess_len_nxt = sess_len_r + tfs_pkg::cnt_t'(1);
          end
        end
        2'd1: q_entry.tag = tfs_pkg::FIELD_EXPIRY;
        2'd2: begin
          q_entry.tag = tfs_pkg::FIELD_MAC;
          if (mac_len_r <= tfs_pkg::TOKEN_LIMIT_C) begin
            mac_len_nxt = mac_len_r + tfs_pkg::cnt_t'(1);
          end
        end
        default: q_entry.tag = tfs_pkg::FIELD_OTHER;
      endcase
    end

    sess_wide               = tfs_pkg::wide_t'(sess_len_nxt);
    q_entry.data            = in_tdata;
    q_entry.last            = in_tlast;
    q_entry.flags.too_long  = byte_cnt_nxt > tfs_pkg::TOKEN_LIMIT_C;
    q_entry.flags.sep_bad   = sep_cnt_nxt != tfs_pkg::SEP_TWO;
    q_entry.flags.mac_bad   = mac_len_nxt != tfs_pkg::MAC_CHARS_C;
    q_entry.flags.over_cap  = sess_wide > tfs_pkg::wide_t'(cap_r);
    q_entry.sess_len        = (sess_wide > tfs_pkg::SESS_MAX_C) ? '1
                              : sess_wide[tfs_pkg::SESS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tfs_pkg::CAP_RESET_C;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_cnt_r  <= '0;
      byte_cnt_r <= '0;
      sess_len_r <= '0;
      mac_len_r  <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        // start the next token from scratch
        sep_cnt_r  <= '0;
        byte_cnt_r <= '0;
        sess_len_r <= '0;
        mac_len_r  <= '0;
      end else begin
        sep_cnt_r  <= sep_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        sess_len_r <= sess_len_nxt;
        mac_len_r  <= mac_len_nxt;
      end
    end
  end

endmodule

[design/tfs_queue.sv]
module tfs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfs_pkg::tfs_entry_t push_entry,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output tfs_pkg::tfs_entry_t pop_entry
);

  tfs_pkg::tfs_entry_t         mem_r [tfs_pkg::Q_DEPTH];
  logic [tfs_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  tfs_pkg::q_cnt_t             count_r;
  logic                        do_push, do_pop;

  assign push_ready = count_r != tfs_pkg::Q_DEPTH_C;
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + tfs_pkg::q_cnt_t'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - tfs_pkg::q_cnt_t'(1);
      end
    end
  end

endmodule

[design/tfs_back.sv]
`include "token_field_splitter_defines.svh"

module tfs_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  tfs_pkg::tfs_entry_t     q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic [1:0]              out_field,
  output logic                    out_done,
  output logic [2:0]              out_status,
  output tfs_pkg::sess_t          out_sess_len,
  output logic [tfs_pkg::EXP_W-1:0] out_expiry
);

  logic [tfs_pkg::EXP_W-1:0] acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic                      bad_r, bad_nxt;
  tfs_pkg::exp_cnt_t         chars_r, chars_nxt;

  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic [1:0]                out_field_r;
  logic                      out_done_r;
  logic [2:0]                out_status_r, status_nxt;
  tfs_pkg::sess_t            out_sess_r;
  logic [tfs_pkg::EXP_W-1:0] out_exp_r, exp_nxt;

  tfs_pkg::prod_t            acc_wide, prod;
  logic                      is_digit;
  logic                      exp_ok;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    acc_wide  = tfs_pkg::prod_t'(acc_r);
    is_digit  = (q_entry.data >= tfs_pkg::ZERO_CHAR) && (q_entry.data <= tfs_pkg::NINE_CHAR);
    // acc * 10 + digit as shift-add
    prod      = (acc_wide << 3) + (acc_wide << 1)
                + tfs_pkg::prod_t'(q_entry.data - tfs_pkg::ZERO_CHAR);
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    chars_nxt = chars_r;
    if (q_entry.tag == tfs_pkg::FIELD_EXPIRY) begin
      if (chars_r != tfs_pkg::EXP_CNT_MAX_C) begin
        chars_nxt = chars_r + tfs_pkg::exp_cnt_t'(1);
      end
      if (!bad_r) begin
        if (chars_r == '0 && q_entry.data == tfs_pkg::MINUS_BYTE) begin
          neg_nxt = 1'b1;
        end else if (!is_digit) begin
          bad_nxt = 1'b1;
        end else if (prod > (neg_r ? tfs_pkg::NEG_BOUND_C : tfs_pkg::POS_BOUND_C)) begin
          bad_nxt = 1'b1;
        end else begin
          acc_nxt = prod[tfs_pkg::EXP_W-1:0];
        end
      end
    end
  end

  // An ok token ends in a mac byte, so the expiry state is already final here.
  always_comb begin
    exp_ok = !bad_r && (chars_r != '0) && !(neg_r && chars_r == tfs_pkg::exp_cnt_t'(1));
    if (q_entry.flags.too_long) begin
      status_nxt = tfs_pkg::ST_TOO_LONG;
    end else if (q_entry.flags.sep_bad) begin
      status_nxt = tfs_pkg::ST_FIELD_CNT;
    end else if (q_entry.flags.mac_bad) begin
      status_nxt = tfs_pkg::ST_MAC_LEN;
    end else if (!exp_ok) begin
      status_nxt = tfs_pkg::ST_BAD_EXPIRY;
    end else if (q_entry.flags.over_cap) begin
      status_nxt = tfs_pkg::ST_OVER_CAP;
    end else begin
      status_nxt = tfs_pkg::ST_OK;
    end
    exp_nxt = '0;
    if (status_nxt == tfs_pkg::ST_OK) begin
      exp_nxt = neg_r ? (~acc_r + 1'b1) : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      chars_r <= '0;
    end else if (q_pop) begin
      if (q_entry.last) begin
        acc_r   <= '0;
        neg_r   <= 1'b0;
        bad_r   <= 1'b0;
        chars_r <= '0;
      end else begin
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        bad_r   <= bad_nxt;
        chars_r <= chars_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte_r   <= q_entry.data;
      out_field_r  <= q_entry.tag;
      out_done_r   <= q_entry.last;
      out_status_r <= q_entry.last ? status_nxt : tfs_pkg::ST_OK;
      out_sess_r   <= q_entry.last ? q_entry.sess_len : '0;
      out_exp_r    <= q_entry.last ? exp_nxt : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_field    = out_field_r;
  assign out_done     = out_done_r;
  assign out_status   = out_status_r;
  assign out_sess_len = out_sess_r;
  assign out_expiry   = out_exp_r;

  `TFS_ASSERT_IMP(a_status_only_on_done, out_valid_r && !out_done_r, out_status_r == tfs_pkg::ST_OK && out_sess_r == '0, "summary fields set on a non-final request")
  `TFS_ASSERT_IMP(a_expiry_zero_on_error, out_valid_r && out_status_r != tfs_pkg::ST_OK, out_exp_r == '0, "expiry reported with an error status")
  `TFS_ASSERT_IMP(a_idle_parser_clear, chars_r == '0, acc_r == '0 && !neg_r && !bad_r, "expiry parser state without expiry bytes")
  `TFS_ASSERT(a_no_pop_when_empty, !(q_pop && !q_valid), "pop from empty queue")

endmodule

[design/token_field_splitter.sv]
// channel  | direction | tdata (low bit up)                          | tuser      | tlast
// in_      | to block  | data_byte[7:0]                               | -          | last_byte
// out_     | from block| byte_out, status, session_len, expiry_value  | byte_field | done_res
// cfg_     | to block  | session_cap on cfg_wr_data when cfg_wr_en    | -          | -
//
// One byte per cycle sustained while out_tready is high; an accepted byte is written to
// a two-entry queue (front classifier), then via the expiry parser into the output register.
// The expiry parser does one shift-add and bound compare per byte.
// rst_n is synchronous, active low; session_cap returns to 1024 and token state clears.
// in_tready drops only when the queue is full, i.e. after out_tready has been low.
module token_field_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // byte_out[7:0], status[10:8], session_len[21:11],
                                  // expiry_value[85:22], zero[87:86]
  output logic [1:0]  out_tuser,  // byte_field[1:0]
  output logic        out_tlast
);

  tfs_pkg::tfs_entry_t       push_entry, pop_entry;
  logic                      push, push_ready, pop, pop_valid;
  logic [7:0]                out_byte;
  logic [2:0]                out_status;
  tfs_pkg::sess_t            out_sess_len;
  logic [tfs_pkg::EXP_W-1:0] out_expiry;

  tfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_ready     (push_ready),
    .q_push      (push),
    .q_entry     (push_entry)
  );

  tfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  tfs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_entry      (pop_entry),
    .q_pop        (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_byte),
    .out_field    (out_tuser),
    .out_done     (out_tlast),
    .out_status   (out_status),
    .out_sess_len (out_sess_len),
    .out_expiry   (out_expiry)
  );

  assign out_tdata = {2'b00, out_expiry, out_sess_len, out_status, out_byte};

endmodule

[tb/tb_token_field_splitter.sv]
`timescale 1ns / 1ps

module tb_token_field_splitter;
  import tfs_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  field_tag;
    logic        done;
    logic [2:0]  status;
    logic [10:0] sess_len;
    logic [63:0] expiry;
  } byte_result_t;

  typedef struct {
    logic [10:0] cap;
    int          sess_n;
    string       expiry;
    int          mac_n;
    int          seps;
    bit          pinned;
    logic [2:0]  status;
    logic [63:0] value;
  } token_row_t;

  localparam logic [63:0] POS_LIMIT    = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_LIMIT    = 64'h8000_0000_0000_0000;
  localparam int          RANDOM_BYTES = 1950;
  localparam int          PIPE_CYCLES  = 4;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // token state mirrored from the block
  logic [10:0] cap_reg    = 11'd1024;
  logic [1:0]  seps_seen  = '0;
  logic [10:0] tok_bytes  = '0;
  logic [10:0] sess_bytes = '0;
  logic [10:0] mac_bytes  = '0;
  logic [63:0] exp_mag    = '0;
  logic        exp_neg    = 1'b0;
  logic        exp_bad    = 1'b0;
  logic [4:0]  exp_chars  = '0;

  byte_result_t pending_results[$];
  token_row_t   token_rows[$];
  int           fail_count = 0;
  bit           in_calm    = 1'b0;
  bit           out_calm   = 1'b0;
  int           ready_hold = 0;
  string        bound_texts[$] = '{"9223372036854775807", "-9223372036854775808",
                                   "9223372036854775808", "-9223372036854775809",
                                   "-", "", "0", "-0"};

  token_field_splitter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function void clear_token();
    seps_seen  = '0;
    tok_bytes  = '0;
    sess_bytes = '0;
    mac_bytes  = '0;
    exp_mag    = '0;
    exp_neg    = 1'b0;
    exp_bad    = 1'b0;
    exp_chars  = '0;
  endfunction

  function automatic byte_result_t split_byte(logic [7:0] b, logic last);
    byte_result_t r;
    logic [4:0]   pos;
    logic [63:0]  d;
    logic [63:0]  bound;
    bit           exp_ok;
    r = '0;
    r.byte_out = b;
    r.done = last;
    if (tok_bytes <= TOKEN_LIMIT) tok_bytes++;
    if (b == SEP_BYTE) begin
      r.field_tag = FIELD_OTHER;
      if (seps_seen != 2'd3) seps_seen++;
    end else if (seps_seen == 2'd0) begin
      r.field_tag = FIELD_SESSION;
      if (sess_bytes <= TOKEN_LIMIT) sess_bytes++;
    end else if (seps_seen == 2'd1) begin
      r.field_tag = FIELD_EXPIRY;
      pos = exp_chars;
      if (exp_chars != 5'd31) exp_chars++;
      if (!exp_bad) begin
        if (pos == 0 && b == MINUS_BYTE) begin
          exp_neg = 1'b1;
        end else if (b < ZERO_CHAR || b > NINE_CHAR) begin
          exp_bad = 1'b1;
        end else begin
          d = 64'(b - ZERO_CHAR);
          bound = exp_neg ? NEG_LIMIT : POS_LIMIT;
          // stop accumulating once the next digit would pass the bound
          if (exp_mag > (bound - d) / 64'd10) exp_bad = 1'b1;
          else exp_mag = exp_mag * 64'd10 + d;
        end
      end
    end else if (seps_seen == 2'd2) begin
      r.field_tag = FIELD_MAC;
      if (mac_bytes <= TOKEN_LIMIT) mac_bytes++;
    end else begin
      r.field_tag = FIELD_OTHER;
    end

    if (last) begin
      exp_ok = !exp_bad && exp_chars != 0 && !(exp_neg && exp_chars == 5'd1);
      if (tok_bytes > TOKEN_LIMIT) r.status = ST_TOO_LONG;
      else if (seps_seen != SEP_TWO) r.status = ST_FIELD_CNT;
      else if (mac_bytes != MAC_CHARS) r.status = ST_MAC_LEN;
      else if (!exp_ok) r.status = ST_BAD_EXPIRY;
      else if (sess_bytes > cap_reg) r.status = ST_OVER_CAP;
      else r.status = ST_OK;
      r.sess_len = sess_bytes;
      if (r.status == ST_OK) r.expiry = exp_neg ? -exp_mag : exp_mag;
      clear_token();
    end
    return r;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == SEP_BYTE);
    return c;
  endfunction

  task automatic add_row(logic [10:0] cap, int sess_n, string expiry, int mac_n, int seps,
                         bit pinned, logic [2:0] status, logic [63:0] value);
    token_row_t row;
    row.cap = cap;
    row.sess_n = sess_n;
    row.expiry = expiry;
    row.mac_n = mac_n;
    row.seps = seps;
    row.pinned = pinned;
    row.status = status;
    row.value = value;
    token_rows.push_back(row);
  endtask

  task automatic make_token(int sess_n, byte_q_t exp_q, int mac_n, int seps,
                            output byte_q_t toks);
    int idx;
    toks = {};
    repeat (sess_n) toks.push_back(body_byte());
    if (seps >= 1) begin
      toks.push_back(SEP_BYTE);
      foreach (exp_q[i]) toks.push_back(exp_q[i]);
    end
    if (seps >= 2) begin
      toks.push_back(SEP_BYTE);
      repeat (mac_n) begin
        idx = $urandom_range(0, 16);
        if (idx == 16) toks.push_back(body_byte());
        else if (idx < 10) toks.push_back(ZERO_CHAR + 8'(idx));
        else toks.push_back(8'h61 + 8'(idx - 10));
      end
    end
    // surplus past the third separator may hold anything
    for (int s = 3; s <= seps; s++) begin
      toks.push_back(SEP_BYTE);
      repeat ($urandom_range(0, 4)) toks.push_back(8'($urandom));
    end
    if (toks.size() == 0) toks.push_back(body_byte());
  endtask

  task automatic push_byte(logic [7:0] b, logic last, bit pinned, logic [2:0] pin_status,
                           logic [63:0] pin_value);
    byte_result_t want;
    int           gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    want = split_byte(b, last);
    if (pinned && last) begin
      want.status = pin_status;
      want.expiry = pin_value;
    end
    pending_results.push_back(want);
    gap = in_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_token(byte_q_t toks, bit pinned, logic [2:0] pin_status,
                            logic [63:0] pin_value);
    if ($urandom_range(0, 3) == 0) in_calm = !in_calm;
    foreach (toks[i])
      push_byte(toks[i], i == toks.size() - 1, pinned, pin_status, pin_value);
  endtask

  task automatic set_cap(logic [10:0] v);
    // drain the pipe before touching the register
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = v;
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      ready_hold = out_calm ? 0 : $urandom_range(0, 16);
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    out_tready <= (ready_hold == 0);
  end

  always @(posedge clk) begin
    byte_result_t got;
    byte_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.byte_out  = out_tdata[7:0];
      got.status    = out_tdata[10:8];
      got.sess_len  = out_tdata[21:11];
      got.expiry    = out_tdata[85:22];
      got.field_tag = out_tuser;
      got.done      = out_tlast;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unrequested result byte %h field %0d last %0b status %0d",
                 $time, got.byte_out, got.field_tag, got.done, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: mismatch expected byte %h field %0d last %0b status %0d len %0d exp %0d",
                   $time, want.byte_out, want.field_tag, want.done, want.status,
                   want.sess_len, $signed(want.expiry));
          $display("%0t:          actual   byte %h field %0d last %0b status %0d len %0d exp %0d",
                   $time, got.byte_out, got.field_tag, got.done, got.status,
                   got.sess_len, $signed(got.expiry));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    token_row_t  row;
    byte_q_t     toks;
    byte_q_t     exp_q;
    string       pick;
    int          phase_bytes;
    int          kind;
    int          sess_n;
    int          n;
    int          mode;
    logic [10:0] v;

    clear_token();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(11'd1024, 8, "0", 64, 2, 1, ST_OK, 64'd0);
    add_row(11'd1024, 8, "9223372036854775807", 64, 2, 1, ST_OK, POS_LIMIT);
    add_row(11'd1024, 8, "-9223372036854775808", 64, 2, 1, ST_OK, NEG_LIMIT);
    add_row(11'd1024, 8, "9223372036854775808", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "-9223372036854775809", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "99999999999999999999", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "-", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "1-2", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "12/", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "4:", 64, 2, 1, ST_BAD_EXPIRY, 64'd0);
    add_row(11'd1024, 8, "000000000000000000000000000000000042", 64, 2, 1, ST_OK, 64'd42);
    add_row(11'd1024, 8, "-0", 64, 2, 1, ST_OK, 64'd0);
    add_row(11'd1024, 8, "x", 63, 2, 1, ST_MAC_LEN, 64'd0);
    add_row(11'd1024, 8, "5", 65, 2, 1, ST_MAC_LEN, 64'd0);
    add_row(11'd1024, 5, "5", 0, 1, 1, ST_FIELD_CNT, 64'd0);
    add_row(11'd1024, 5, "5", 64, 4, 1, ST_FIELD_CNT, 64'd0);
    add_row(11'd1024, 5, "", 0, 0, 1, ST_FIELD_CNT, 64'd0);
    add_row(11'd1024, 0, "31", 64, 2, 1, ST_OK, 64'd31);
    add_row(11'd1024, 1024, "123", 64, 2, 1, ST_OK, 64'd123);
    add_row(11'd1024, 1025, "123", 64, 2, 1, ST_OVER_CAP, 64'd0);
    add_row(11'd1024, 1050, "1234567890123", 64, 2, 1, ST_TOO_LONG, 64'd0);
    add_row(11'd0, 0, "7", 64, 2, 1, ST_OK, 64'd7);
    add_row(11'd0, 1, "7", 64, 2, 1, ST_OVER_CAP, 64'd0);
    add_row(11'd0, 3, "7", 10, 2, 1, ST_MAC_LEN, 64'd0);
    add_row(11'd2047, 1040, "5", 64, 2, 1, ST_OK, 64'd5);
    add_row(11'd2047, 1200, "", 0, 0, 1, ST_TOO_LONG, 64'd0);
    add_row(11'd2047, 0, "", 0, 1, 1, ST_FIELD_CNT, 64'd0);
    add_row(11'd2047, 12, "-17", 64, 2, 0, ST_OK, 64'd0);
    add_row(11'd2047, 3, "+5", 64, 2, 0, ST_OK, 64'd0);

    foreach (token_rows[i]) begin
      row = token_rows[i];
      if (row.cap != cap_reg) set_cap(row.cap);
      exp_q = {};
      for (int k = 0; k < row.expiry.len(); k++) exp_q.push_back(row.expiry[k]);
      make_token(row.sess_n, exp_q, row.mac_n, row.seps, toks);
      send_token(toks, row.pinned, row.status, row.value);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       v = 11'($urandom_range(1, 24));
        1:       v = 11'd0;
        2:       v = 11'd2047;
        default: v = 11'd1024;
      endcase
      set_cap(v);
      phase_bytes = 0;
      while (phase_bytes < RANDOM_BYTES / 4) begin
        kind = $urandom_range(0, 9);
        sess_n = ($urandom_range(0, 39) == 0) ? $urandom_range(1000, 1120)
                                             : $urandom_range(0, 24);
        if (kind >= 8) begin
          // noise: short runs of arbitrary bytes, separators sprinkled in
          toks = {};
          repeat ($urandom_range(1, 30))
            toks.push_back(($urandom_range(0, 4) == 0) ? SEP_BYTE : 8'($urandom));
        end else begin
          mode = $urandom_range(0, 5);
          exp_q = {};
          n = (mode == 1) ? $urandom_range(18, 22) : $urandom_range(1, 19);
          if ($urandom_range(0, 2) == 0) exp_q.push_back(MINUS_BYTE);
          repeat (n) exp_q.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
          if (mode == 2) exp_q.insert($urandom_range(0, exp_q.size()), body_byte());
          if (mode == 0) begin
            pick = bound_texts[$urandom_range(0, bound_texts.size() - 1)];
            exp_q = {};
            for (int k = 0; k < pick.len(); k++) exp_q.push_back(pick[k]);
          end
          if (kind == 7)
            make_token(sess_n, exp_q, $urandom_range(0, 70), $urandom_range(0, 4), toks);
          else
            make_token(sess_n, exp_q,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(60, 68) : MAC_CHARS,
                       2, toks);
        end
        send_token(toks, 1'b0, ST_OK, 64'd0);
        phase_bytes += toks.size();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES * 4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
